// ===== design/ffst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-free slot table package
// Shared types, codes and defaults for the slot table and its search unit.
// ----------------------------------------------------------------------------
package ffst_pkg;

   localparam int CAPACITY_DEFAULT   = 256;
   localparam int DATA_WIDTH_DEFAULT = 64;

   localparam int LIMIT_W     = 9;
   localparam int SLOT_W      = 8;
   localparam int COUNT_W     = 16;
   localparam int GROUP_SIZE  = 16;
   localparam int GROUP_OFF_W = 4;

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_GET    = 2'd2,
      ACT_SET    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic               found;
      logic [LIMIT_W-1:0] index;
   } search_result_type;

endpackage

// ===== design/ffst_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one table request per transfer.
// ----------------------------------------------------------------------------
interface ffst_req_if #(
   parameter int DATA_WIDTH = ffst_pkg::DATA_WIDTH_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic [1:0]            action;
   logic [7:0]            slot_index;
   logic [DATA_WIDTH-1:0] write_data;

   modport source (output valid, output action, output slot_index, output write_data,
                   input ready);
   modport sink   (input valid, input action, input slot_index, input write_data,
                   output ready);
endinterface

// ===== design/ffst_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one table result per transfer.
// ----------------------------------------------------------------------------
interface ffst_rsp_if #(
   parameter int DATA_WIDTH = ffst_pkg::DATA_WIDTH_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic [1:0]            status;
   logic [7:0]            result_index;
   logic [DATA_WIDTH-1:0] read_data;
   logic [15:0]           used_count;

   modport source (output valid, output status, output result_index, output read_data,
                   output used_count, input ready);
   modport sink   (input valid, input status, input result_index, input read_data,
                   input used_count, output ready);
endinterface

// ===== design/ffst_free_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-free slot search
// Registers a per-group summary of free slots below the limit, then picks the
// lowest group that has a free slot.
// ----------------------------------------------------------------------------
module ffst_free_search #(
   parameter int SLOTS = ffst_pkg::CAPACITY_DEFAULT
) (
   input  logic                              clock,
   input  logic                              load,
   input  logic [SLOTS-1:0]                  occupied,
   input  logic [ffst_pkg::LIMIT_W-1:0]      limit,
   output ffst_pkg::search_result_type       result
);
   import ffst_pkg::*;

   localparam int NGROUPS = (SLOTS + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int PAD_W   = NGROUPS * GROUP_SIZE;

   logic [PAD_W-1:0]       occ_pad;
   logic [NGROUPS-1:0]     group_any_in;
   logic [NGROUPS-1:0]     group_any_ff;
   logic [GROUP_OFF_W-1:0] group_off_in [NGROUPS];
   logic [GROUP_OFF_W-1:0] group_off_ff [NGROUPS];

   assign occ_pad = PAD_W'(occupied);

   always_comb begin
      int slot;
      for (int g = 0; g < NGROUPS; g++) begin
         group_any_in[g] = 1'b0;
         group_off_in[g] = '0;
         for (int b = GROUP_SIZE - 1; b >= 0; b--) begin
            slot = g * GROUP_SIZE + b;
            if (!occ_pad[slot] && (slot < int'(limit))) begin
               group_any_in[g] = 1'b1;
               group_off_in[g] = GROUP_OFF_W'(b);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         group_any_ff <= group_any_in;
         group_off_ff <= group_off_in;
      end
   end

   always_comb begin
      result.found = 1'b0;
      result.index = '0;
      for (int g = NGROUPS - 1; g >= 0; g--) begin
         if (group_any_ff[g]) begin
            result.found = 1'b1;
            result.index = LIMIT_W'(g * GROUP_SIZE) + LIMIT_W'(group_off_ff[g]);
         end
      end
   end

endmodule

// ===== design/first_free_slot_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-free slot table
// Handle table with lowest-free allocation, removal, read and overwrite.
//
//   Channel  Direction  Transfer holds
//   req      in         action, slot_index, write_data
//   rsp      out        status, result_index, read_data, used_count
//   csr      in         active_slots, written when csr_write_enable is high
//
// For each request, the accept cycle reads the slot memory and registers the
// per-group free summary, and the execute state then finishes the
// read-modify-write of the memory and occupancy bits. A request is accepted
// only while no other is in flight. The result register frees the input side
// while a result waits; a stalled response holds the execute state. Reset
// clears occupancy and count, sets the limit to 256; no clearing pass is run.
// ----------------------------------------------------------------------------
module first_free_slot_table_top #(
   parameter int CAPACITY   = ffst_pkg::CAPACITY_DEFAULT,
   parameter int DATA_WIDTH = ffst_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   ffst_req_if.sink                      req_chan,
   ffst_rsp_if.source                    rsp_chan,
   input  logic                          csr_write_enable,
   input  logic [ffst_pkg::LIMIT_W-1:0]  csr_write_data
);
   import ffst_pkg::*;

   localparam int SLOTS = (CAPACITY < 511) ? CAPACITY : 511;
   localparam int IDX_W = $clog2(SLOTS);

   state_type state_ff;
   state_type state_in;

   logic [LIMIT_W-1:0]    active_ff;
   logic [LIMIT_W-1:0]    limit;
   logic [SLOTS-1:0]      occ_ff;
   logic [COUNT_W-1:0]    used_ff;
   logic [COUNT_W-1:0]    used_in;

   logic [DATA_WIDTH-1:0] slot_mem [SLOTS];
   logic [DATA_WIDTH-1:0] mem_rdata_ff;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   logic [IDX_W-1:0]      req_addr;
   logic [LIMIT_W-1:0]    req_index_ext;

   action_type            action_ff;
   logic [IDX_W-1:0]      addr_ff;
   logic [DATA_WIDTH-1:0] data_ff;
   logic                  in_range_ff;

   logic                  req_fire;
   logic                  commit;
   logic                  occ_we;
   logic                  occ_wval;
   logic                  occ_hit;

   search_result_type     search;
   logic [IDX_W-1:0]      search_addr;

   status_type            status_in;
   logic [SLOT_W-1:0]     rindex_in;
   logic [DATA_WIDTH-1:0] rdata_in;

   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic [SLOT_W-1:0]     rsp_index_ff;
   logic [DATA_WIDTH-1:0] rsp_data_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   assign limit         = (active_ff > LIMIT_W'(SLOTS)) ? LIMIT_W'(SLOTS) : active_ff;
   assign req_index_ext = LIMIT_W'(req_chan.slot_index);
   assign req_addr      = req_index_ext[IDX_W-1:0];
   assign req_fire      = req_chan.valid && req_chan.ready;
   assign search_addr   = search.index[IDX_W-1:0];
   assign occ_hit       = occ_ff[addr_ff];

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= LIMIT_W'(256);
      end else if (csr_write_enable) begin
         active_ff <= csr_write_data;
      end
   end

   ffst_free_search #(
      .SLOTS (SLOTS)
   ) u_search (
      .clock    (clock),
      .load     (req_fire),
      .occupied (occ_ff),
      .limit    (limit),
      .result   (search)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (commit) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_chan.ready = 1'b0;
      commit         = 1'b0;
      unique case (state_ff)
         S_IDLE: req_chan.ready = 1'b1;
         S_EXEC: commit = !rsp_valid_ff || rsp_chan.ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         action_ff   <= action_type'(req_chan.action);
         addr_ff     <= req_addr;
         data_ff     <= req_chan.write_data;
         in_range_ff <= req_index_ext < limit;
      end
   end

   // Slot memory.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= data_ff;
      end
      if (req_fire) begin
         mem_rdata_ff <= slot_mem[req_addr];
      end
   end

   // Result and update logic.
   always_comb begin
      status_in = STATUS_OK;
      rindex_in = '0;
      rdata_in  = '0;
      used_in   = used_ff;
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      occ_we    = 1'b0;
      occ_wval  = 1'b0;
      unique case (action_ff)
         ACT_ADD: begin
            if (search.found) begin
               mem_we    = commit;
               mem_waddr = search_addr;
               occ_we    = commit;
               occ_wval  = data_ff != '0;
               rindex_in = search.index[SLOT_W-1:0];
               if (used_ff != '1) used_in = used_ff + COUNT_W'(1);
            end else begin
               status_in = STATUS_FULL;
            end
         end
         ACT_REMOVE: begin
            if (!in_range_ff) begin
               status_in = STATUS_RANGE;
            end else if (occ_hit) begin
               occ_we = commit;
               if (used_ff != '0) used_in = used_ff - COUNT_W'(1);
            end
         end
         ACT_GET: begin
            if (!in_range_ff) begin
               status_in = STATUS_RANGE;
            end else if (occ_hit) begin
               rdata_in = mem_rdata_ff;
            end
         end
         ACT_SET: begin
            if (!in_range_ff) begin
               status_in = STATUS_RANGE;
            end else begin
               mem_we   = commit;
               occ_we   = commit;
               occ_wval = data_ff != '0;
               rdata_in = data_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff  <= '0;
         used_ff <= '0;
      end else begin
         if (occ_we) occ_ff[mem_waddr] <= occ_wval;
         if (commit) used_ff <= used_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_status_ff <= status_in;
         rsp_index_ff  <= rindex_in;
         rsp_data_ff   <= rdata_in;
         rsp_count_ff  <= used_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.result_index = rsp_index_ff;
   assign rsp_chan.read_data    = rsp_data_ff;
   assign rsp_chan.used_count   = rsp_count_ff;

   // The block stays idle until a request is transferred.
   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !req_fire) |=> state_ff == S_IDLE)
      else $error("left idle without a request transfer");

   // A new response only appears after a committed request.
   a_rsp_after_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(commit))
      else $error("response raised without a commit");

   // A failed add reports a full table.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (commit && action_ff == ACT_ADD && !search.found) |=> rsp_status_ff == STATUS_FULL)
      else $error("failed add did not report full");

   // An add of a nonzero handle marks its slot occupied.
   a_add_occupies: assert property (@(posedge clock) disable iff (reset)
      (commit && action_ff == ACT_ADD && search.found && data_ff != '0)
      |=> occ_ff[$past(search_addr)])
      else $error("added slot not marked occupied");

   // The used count never wraps past its maximum.
   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      (commit && used_ff == '1 && action_ff != ACT_REMOVE) |=> used_ff == '1)
      else $error("used count wrapped");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-free slot table testbench
// Drives add, remove, get and set requests into the slot table and checks
// every result against an internal model of the table, its used count and the
// active-slot limit. A directed opening covers the corner cases, then random
// phases run under several limits with random gaps and stalls on both
// channels. A long receiver stall fills the block and backs up its input. A
// final quiet phase runs with no gaps on either channel.
// ----------------------------------------------------------------------------
module tb;
   import ffst_pkg::*;

   localparam int DW          = DATA_WIDTH_DEFAULT;
   localparam int SLOTS       = CAPACITY_DEFAULT;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int LONG_STALL  = 200;

   typedef struct {
      action_type        action;
      logic [SLOT_W-1:0] slot;
      logic [DW-1:0]     data;
   } table_request;

   typedef struct {
      status_type         status;
      logic [SLOT_W-1:0]  slot;
      logic [DW-1:0]      data;
      logic [COUNT_W-1:0] count;
   } table_result;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_enable = 1'b0;
   logic [LIMIT_W-1:0] csr_write_data = '0;

   ffst_req_if req_if ();
   ffst_rsp_if rsp_if ();

   first_free_slot_table_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   logic [DW-1:0]      slot_words [SLOTS];
   logic [COUNT_W-1:0] handle_count = '0;
   int unsigned        active_slots_cfg = SLOTS;

   table_request pending_requests [$];
   table_result  expected_results [$];

   bit          req_taken = 1'b0;
   int unsigned gap_chance = 0;
   bit          long_stall_pending = 1'b0;
   int unsigned req_gap_left = 0;
   int unsigned rsp_hold_left = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   initial begin
      req_if.valid      = 1'b0;
      req_if.action     = '0;
      req_if.slot_index = '0;
      req_if.write_data = '0;
      rsp_if.ready      = 1'b0;
      foreach (slot_words[k]) slot_words[k] = '0;
   end

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned slot_limit();
      return (active_slots_cfg > SLOTS) ? SLOTS : active_slots_cfg;
   endfunction

   function automatic table_result table_outcome(table_request rq);
      table_result r;
      int unsigned lim;
      int unsigned k;
      lim = slot_limit();
      r.status = STATUS_OK;
      r.slot   = '0;
      r.data   = '0;
      if (rq.action == ACT_ADD) begin
         k = 0;
         while (k < lim && slot_words[k] != '0) k++;
         if (k >= lim) begin
            r.status = STATUS_FULL;
         end else begin
            slot_words[k] = rq.data;
            if (handle_count != '1) handle_count++;
            r.slot = SLOT_W'(k);
         end
      end else if (rq.slot >= lim) begin
         r.status = STATUS_RANGE;
      end else if (rq.action == ACT_REMOVE) begin
         if (slot_words[rq.slot] != '0) begin
            slot_words[rq.slot] = '0;
            if (handle_count != '0) handle_count--;
         end
      end else if (rq.action == ACT_GET) begin
         r.data = slot_words[rq.slot];
      end else begin
         slot_words[rq.slot] = rq.data;
         r.data = rq.data;
      end
      r.count = handle_count;
      return r;
   endfunction

   function automatic table_request random_request();
      table_request rq;
      int unsigned lim;
      int unsigned pick;
      lim = slot_limit();
      pick = $urandom_range(99);
      if (pick < 35) rq.action = ACT_ADD;
      else if (pick < 60) rq.action = ACT_REMOVE;
      else if (pick < 80) rq.action = ACT_GET;
      else rq.action = ACT_SET;
      if (lim > 0 && $urandom_range(99) < 80) rq.slot = SLOT_W'($urandom_range(lim - 1));
      else rq.slot = SLOT_W'($urandom_range(SLOTS - 1));
      pick = $urandom_range(99);
      if (pick < 10) rq.data = '0;
      else if (pick < 15) rq.data = '1;
      else rq.data = {$urandom, $urandom};
      return rq;
   endfunction

   task automatic report_mismatch(string field, logic [DW-1:0] want, logic [DW-1:0] got);
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
   endtask

   task automatic queue_request(action_type act, int unsigned slot, logic [DW-1:0] data);
      table_request rq;
      rq.action = act;
      rq.slot   = SLOT_W'(slot);
      rq.data   = data;
      pending_requests.push_back(rq);
   endtask

   task automatic drain();
      while (pending_requests.size() != 0 || req_if.valid || expected_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_active_slots(int unsigned value);
      drain();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= LIMIT_W'(value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      active_slots_cfg = value;
   endtask

   always @(posedge clock) begin
      table_result seen;
      table_result want;
      table_request rq;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            seen.status = status_type'(rsp_if.status);
            seen.slot   = rsp_if.result_index;
            seen.data   = rsp_if.read_data;
            seen.count  = rsp_if.used_count;
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected transfer, status", '0, DW'(seen.status));
            end else begin
               want = expected_results.pop_front();
               if (seen.status !== want.status)
                  report_mismatch("status", DW'(want.status), DW'(seen.status));
               if (seen.slot !== want.slot)
                  report_mismatch("result_index", DW'(want.slot), DW'(seen.slot));
               if (seen.data !== want.data)
                  report_mismatch("read_data", want.data, seen.data);
               if (seen.count !== want.count)
                  report_mismatch("used_count", DW'(want.count), DW'(seen.count));
            end
         end
         if (req_if.valid && req_if.ready) begin
            rq.action = action_type'(req_if.action);
            rq.slot   = req_if.slot_index;
            rq.data   = req_if.write_data;
            expected_results.push_back(table_outcome(rq));
            req_taken = 1'b1;
         end
      end
   end

   always @(negedge clock) begin
      bit offer;
      offer = 1'b0;
      if (req_taken) pending_requests.delete(0);
      if (!reset) begin
         if (req_if.valid && !req_taken) begin
            offer = 1'b1;
         end else if (req_gap_left > 0) begin
            req_gap_left--;
         end else if (pending_requests.size() > 0) begin
            if (gap_chance > 0 && $urandom_range(99) < gap_chance)
               req_gap_left = $urandom_range(7);
            else
               offer = 1'b1;
         end
      end
      req_if.valid <= offer;
      if (offer) begin
         req_if.action     <= pending_requests[0].action;
         req_if.slot_index <= pending_requests[0].slot;
         req_if.write_data <= pending_requests[0].data;
      end
   end

   always @(negedge clock) begin
      bit accept;
      accept = 1'b0;
      if (!reset) begin
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
         end else if (long_stall_pending) begin
            long_stall_pending = 1'b0;
            rsp_hold_left = LONG_STALL - 1;
         end else if (gap_chance > 0 && $urandom_range(99) < gap_chance) begin
            rsp_hold_left = $urandom_range(7);
         end else begin
            accept = 1'b1;
         end
      end
      rsp_if.ready <= accept;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int unsigned phase_limits [10];
      phase_limits = '{8, 1, 2, 256, 40, 0, 16, 3, 0, 256};
      phase_limits[5] = $urandom_range(300, 1);
      phase_limits[8] = $urandom_range(511, 257);
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      gap_chance = 25;
      queue_request(ACT_SET, 3, 64'h0123_4567_89AB_CDEF);
      queue_request(ACT_REMOVE, 3, '0);
      queue_request(ACT_GET, 3, '0);
      queue_request(ACT_REMOVE, 5, '0);
      queue_request(ACT_ADD, 200, '1);
      queue_request(ACT_ADD, 0, 64'h1);
      queue_request(ACT_ADD, 0, '0);
      queue_request(ACT_ADD, 255, 64'h8000_0000_0000_0000);
      queue_request(ACT_GET, 0, '0);
      queue_request(ACT_GET, 255, '0);
      queue_request(ACT_SET, 255, 64'hA5A5_A5A5_A5A5_A5A5);
      queue_request(ACT_GET, 255, '0);
      queue_request(ACT_SET, 1, '0);
      queue_request(ACT_ADD, 0, 64'h5555_5555_5555_5555);
      queue_request(ACT_REMOVE, 0, '0);
      queue_request(ACT_GET, 0, '0);
      write_active_slots(4);
      queue_request(ACT_ADD, 0, 64'h2);
      queue_request(ACT_ADD, 0, 64'h3);
      queue_request(ACT_ADD, 0, 64'h4);
      queue_request(ACT_GET, 4, '0);
      queue_request(ACT_REMOVE, 200, '0);
      queue_request(ACT_SET, 255, '1);
      write_active_slots(0);
      queue_request(ACT_ADD, 0, 64'h6);
      queue_request(ACT_GET, 0, '0);
      write_active_slots(511);
      queue_request(ACT_GET, 255, '0);

      for (int p = 0; p < 10; p++) begin
         write_active_slots(phase_limits[p]);
         case (p % 3)
            0: gap_chance = 25;
            1: gap_chance = 0;
            default: gap_chance = 50;
         endcase
         if (p == 2) long_stall_pending = 1'b1;
         repeat (58) pending_requests.push_back(random_request());
      end

      gap_chance = 0;
      write_active_slots(SLOTS);
      repeat (40) pending_requests.push_back(random_request());
      drain();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
